// File: src/fpq_pkg.sv
// Package for the Q24.8 fixed-point ALU: widths, opcodes, error codes,
// result type and the shared saturation helpers. No dependencies.
`timescale 1ns / 1ps
package fpq_pkg;

    localparam int WORD_W     = 32;
    localparam int FRAC_W     = 8;
    localparam int QUOT_W     = WORD_W + FRAC_W;
    localparam int MAG_W      = 2 * WORD_W + 1;
    localparam int DIV_STEPS  = 2;
    localparam int DIV_STAGES = QUOT_W / DIV_STEPS;
    localparam int PIPE_DEPTH = DIV_STAGES + 3;

    localparam logic [3:0] OP_ADD  = 4'd0;
    localparam logic [3:0] OP_SUB  = 4'd1;
    localparam logic [3:0] OP_MUL  = 4'd2;
    localparam logic [3:0] OP_DIV  = 4'd3;
    localparam logic [3:0] OP_GT   = 4'd4;
    localparam logic [3:0] OP_LT   = 4'd5;
    localparam logic [3:0] OP_GE   = 4'd6;
    localparam logic [3:0] OP_LE   = 4'd7;
    localparam logic [3:0] OP_EQ   = 4'd8;
    localparam logic [3:0] OP_NE   = 4'd9;
    localparam logic [3:0] OP_MIN  = 4'd10;
    localparam logic [3:0] OP_MAX  = 4'd11;
    localparam logic [3:0] OP_INC  = 4'd12;
    localparam logic [3:0] OP_DEC  = 4'd13;
    localparam logic [3:0] OP_FINT = 4'd14;
    localparam logic [3:0] OP_TINT = 4'd15;

    localparam logic [1:0] ERR_OK   = 2'd0;
    localparam logic [1:0] ERR_DIV0 = 2'd1;
    localparam logic [1:0] ERR_SAT  = 2'd2;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [WORD_W-1:0]        t_umag;
    typedef logic [MAG_W-1:0]         t_wide;

    typedef struct packed {
        t_word      val;
        logic       cmp;
        logic [1:0] err;
    } t_res;

    // Magnitude of a signed word; the most negative value maps to 2^(W-1).
    function automatic t_umag f_mag(input t_word v);
        f_mag = v[WORD_W-1] ? (t_umag'(0) - t_umag'(v)) : t_umag'(v);
    endfunction

    // Applies the sign to a magnitude, clamping to the word range.
    function automatic t_res f_finish(input logic neg, input t_wide mag);
        t_wide lim;
        t_wide m;
        t_res  res;
        lim = neg ? (t_wide'(1) << (WORD_W - 1)) : ((t_wide'(1) << (WORD_W - 1)) - t_wide'(1));
        m       = mag;
        res.cmp = 1'b0;
        res.err = ERR_OK;
        if (mag > lim) begin
            m       = lim;
            res.err = ERR_SAT;
        end
        res.val  = neg ? t_word'(t_umag'(0) - m[WORD_W-1:0]) : t_word'(m[WORD_W-1:0]);
        f_finish = res;
    endfunction

endpackage

// File: src/fpq_in_if.sv
// Input channel of the fixed-point ALU: opcode and two raw operands.
// Depends on fpq_pkg.
`timescale 1ns / 1ps
interface fpq_in_if;
    logic           valid;
    logic           ready;
    logic [3:0]     kind;
    fpq_pkg::t_word operand_a;
    fpq_pkg::t_word operand_b;

    modport source (output valid, kind, operand_a, operand_b, input ready);
    modport sink (input valid, kind, operand_a, operand_b, output ready);
endinterface

// File: src/fpq_out_if.sv
// Output channel of the fixed-point ALU: raw result, compare flag, error code.
// Depends on fpq_pkg.
`timescale 1ns / 1ps
interface fpq_out_if;
    logic           valid;
    logic           ready;
    fpq_pkg::t_word result_value;
    logic           compare_true;
    logic [1:0]     error_code;

    modport source (output valid, result_value, compare_true, error_code, input ready);
    modport sink (input valid, result_value, compare_true, error_code, output ready);
endinterface

// File: src/fpq_div_pipe.sv
// Pipelined restoring divider for fixed-point division with rounding and
// saturation in its last stage. Depends on fpq_pkg.
`timescale 1ns / 1ps
module fpq_div_pipe (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  fpq_pkg::t_umag       i_ma,
    input  fpq_pkg::t_umag       i_mb,
    input  logic                 i_neg,
    output fpq_pkg::t_res        o_res
);

    typedef struct packed {
        logic [fpq_pkg::QUOT_W-1:0] nq;
        fpq_pkg::t_umag             r;
        fpq_pkg::t_umag             d;
        logic                       neg;
        logic                       dz;
    } t_dst;

    t_dst r_st [fpq_pkg::DIV_STAGES];
    t_dst n_st [fpq_pkg::DIV_STAGES];
    t_dst w_src [fpq_pkg::DIV_STAGES];

    always_comb begin
        w_src[0].nq  = {i_ma, {fpq_pkg::FRAC_W{1'b0}}};
        w_src[0].r   = '0;
        w_src[0].d   = i_mb;
        w_src[0].neg = i_neg;
        w_src[0].dz  = (i_mb == '0);
    end

    genvar gs;
    generate
        for (gs = 0; gs < fpq_pkg::DIV_STAGES; gs++) begin : g_stage
            if (gs > 0) begin : g_link
                assign w_src[gs] = r_st[gs-1];
            end

            // Each stage retires DIV_STEPS quotient bits into the low end of nq.
            always_comb begin
                logic [fpq_pkg::WORD_W:0] t;
                n_st[gs] = w_src[gs];
                for (int k = 0; k < fpq_pkg::DIV_STEPS; k++) begin
                    t = {n_st[gs].r, n_st[gs].nq[fpq_pkg::QUOT_W-1]};
                    n_st[gs].nq = n_st[gs].nq << 1;
                    if (t >= {1'b0, n_st[gs].d}) begin
                        t = t - {1'b0, n_st[gs].d};
                        n_st[gs].nq[0] = 1'b1;
                    end
                    n_st[gs].r = t[fpq_pkg::WORD_W-1:0];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_st[gs] <= n_st[gs];
                end
            end
        end
    endgenerate

    // Half or more of the divisor left over rounds the magnitude up.
    t_dst                       w_last;
    logic                       w_rnd;
    logic [fpq_pkg::QUOT_W:0]   w_q1;
    fpq_pkg::t_res              n_res;

    assign w_last = r_st[fpq_pkg::DIV_STAGES-1];
    assign w_rnd  = ({w_last.r, 1'b0} >= {1'b0, w_last.d});
    assign w_q1   = {1'b0, w_last.nq} + {{fpq_pkg::QUOT_W{1'b0}}, w_rnd};

    always_comb begin
        n_res = fpq_pkg::f_finish(w_last.neg, fpq_pkg::t_wide'(w_q1));
        if (w_last.dz) begin
            n_res.val = '0;
            n_res.err = fpq_pkg::ERR_DIV0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_res <= n_res;
        end
    end

endmodule

// File: src/fixed_point_alu_q24_8_core.sv
// Top level of the signed Q24.8 fixed-point ALU pipeline.
// Depends on fpq_pkg, fpq_in_if, fpq_out_if and fpq_div_pipe.
`timescale 1ns / 1ps
// The core accepts one operation per clock cycle while the output register
// is free or being taken, and returns one result for each, in order, once
// it has passed through every register of the pipeline. The depth is
// set by the divider, which retires two quotient bits in each of its twenty
// stages; every other operation is carried alongside it in a delay line so that
// all results leave in order. The whole pipeline advances together: when the
// output register holds a result that has not been taken, every stage and the
// input ready are held, so nothing is lost or repeated. Results saturate on
// overflow with error code two, and division by zero yields zero with error
// code one.
module fixed_point_alu_q24_8_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fpq_in_if.sink    i_in,
    fpq_out_if.source o_out
);

    localparam int DLY = fpq_pkg::DIV_STAGES - 1;

    // Valid bit for each pipeline depth; the last one is the output register.
    logic [fpq_pkg::PIPE_DEPTH-1:0] r_vld;
    logic                           w_adv;

    assign w_adv      = !r_vld[fpq_pkg::PIPE_DEPTH-1] || o_out.ready;
    assign i_in.ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[fpq_pkg::PIPE_DEPTH-2:0], i_in.valid};
        end
    end

    // Stage one: capture the operands and their magnitudes.
    logic [3:0]       r1_kind;
    fpq_pkg::t_word   r1_a;
    fpq_pkg::t_word   r1_b;
    fpq_pkg::t_umag   r1_ma;
    fpq_pkg::t_umag   r1_mb;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_kind <= i_in.kind;
            r1_a    <= i_in.operand_a;
            r1_b    <= i_in.operand_b;
            r1_ma   <= fpq_pkg::f_mag(i_in.operand_a);
            r1_mb   <= fpq_pkg::f_mag(i_in.operand_b);
        end
    end

    logic w_neg_a;
    logic w_neg_q;
    assign w_neg_a = r1_a[fpq_pkg::WORD_W-1];
    assign w_neg_q = r1_a[fpq_pkg::WORD_W-1] ^ r1_b[fpq_pkg::WORD_W-1];

    // Division runs in its own pipeline fed straight from stage one.
    fpq_pkg::t_res w_div_res;

    fpq_div_pipe u_div (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_ma  (r1_ma),
        .i_mb  (r1_mb),
        .i_neg (w_neg_q),
        .o_res (w_div_res)
    );

    // Saturating clamp of a sum that carries one guard bit.
    function automatic fpq_pkg::t_res f_sat(input logic signed [fpq_pkg::WORD_W:0] s);
        fpq_pkg::t_res res;
        res.cmp = 1'b0;
        res.err = fpq_pkg::ERR_OK;
        res.val = fpq_pkg::t_word'(s[fpq_pkg::WORD_W-1:0]);
        if (s[fpq_pkg::WORD_W] != s[fpq_pkg::WORD_W-1]) begin
            res.err = fpq_pkg::ERR_SAT;
            res.val = {s[fpq_pkg::WORD_W], {(fpq_pkg::WORD_W-1){!s[fpq_pkg::WORD_W]}}};
        end
        f_sat = res;
    endfunction

    // Stage two: all operations other than multiply and divide, and the raw product.
    logic signed [fpq_pkg::WORD_W:0] w_ax;
    logic signed [fpq_pkg::WORD_W:0] w_bx;
    logic                            w_lt;
    logic                            w_gt;
    logic [fpq_pkg::WORD_W:0]        w_tint;
    fpq_pkg::t_res                   n2_res;

    assign w_ax   = {r1_a[fpq_pkg::WORD_W-1], r1_a};
    assign w_bx   = {r1_b[fpq_pkg::WORD_W-1], r1_b};
    assign w_lt   = (r1_a < r1_b);
    assign w_gt   = (r1_b < r1_a);
    assign w_tint = ({1'b0, r1_ma} + ((fpq_pkg::WORD_W+1)'(1) << (fpq_pkg::FRAC_W - 1)))
                    >> fpq_pkg::FRAC_W;

    always_comb begin
        n2_res.val = '0;
        n2_res.cmp = 1'b0;
        n2_res.err = fpq_pkg::ERR_OK;
        case (r1_kind)
            fpq_pkg::OP_ADD:  n2_res = f_sat(w_ax + w_bx);
            fpq_pkg::OP_SUB:  n2_res = f_sat(w_ax - w_bx);
            fpq_pkg::OP_GT:   n2_res.cmp = w_gt;
            fpq_pkg::OP_LT:   n2_res.cmp = w_lt;
            fpq_pkg::OP_GE:   n2_res.cmp = !w_lt;
            fpq_pkg::OP_LE:   n2_res.cmp = !w_gt;
            fpq_pkg::OP_EQ:   n2_res.cmp = (r1_a == r1_b);
            fpq_pkg::OP_NE:   n2_res.cmp = (r1_a != r1_b);
            fpq_pkg::OP_MIN:  n2_res.val = w_lt ? r1_a : r1_b;
            fpq_pkg::OP_MAX:  n2_res.val = w_gt ? r1_a : r1_b;
            fpq_pkg::OP_INC:  n2_res = f_sat(w_ax + (fpq_pkg::WORD_W+1)'(1));
            fpq_pkg::OP_DEC:  n2_res = f_sat(w_ax - (fpq_pkg::WORD_W+1)'(1));
            fpq_pkg::OP_FINT: n2_res = fpq_pkg::f_finish(w_neg_a,
                                  fpq_pkg::t_wide'({r1_ma, {fpq_pkg::FRAC_W{1'b0}}}));
            fpq_pkg::OP_TINT: n2_res = fpq_pkg::f_finish(w_neg_a, fpq_pkg::t_wide'(w_tint));
            default: begin
                // Multiply and divide are finished in later stages.
                n2_res.val = '0;
            end
        endcase
    end

    fpq_pkg::t_res                    r2_res;
    logic [2*fpq_pkg::WORD_W-1:0]     r2_prod;
    logic                             r2_neg;
    logic                             r2_is_mul;
    logic                             r2_is_div;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_res    <= n2_res;
            r2_prod   <= r1_ma * r1_mb;
            r2_neg    <= w_neg_q;
            r2_is_mul <= (r1_kind == fpq_pkg::OP_MUL);
            r2_is_div <= (r1_kind == fpq_pkg::OP_DIV);
        end
    end

    // Stage three: round the product half away from zero and clamp it.
    fpq_pkg::t_wide w_prnd;
    assign w_prnd = (fpq_pkg::t_wide'(r2_prod) + (fpq_pkg::t_wide'(1) << (fpq_pkg::FRAC_W - 1)))
                    >> fpq_pkg::FRAC_W;

    fpq_pkg::t_res r3_res;
    logic          r3_is_div;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_res    <= r2_is_mul ? fpq_pkg::f_finish(r2_neg, w_prnd) : r2_res;
            r3_is_div <= r2_is_div;
        end
    end

    // Delay line that keeps the other results level with the divider.
    fpq_pkg::t_res r_dly_res [DLY];
    logic          r_dly_div [DLY];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dly_res[0] <= r3_res;
            r_dly_div[0] <= r3_is_div;
            for (int i = 1; i < DLY; i++) begin
                r_dly_res[i] <= r_dly_res[i-1];
                r_dly_div[i] <= r_dly_div[i-1];
            end
        end
    end

    // Output register: pick the divider result where the item was a divide.
    fpq_pkg::t_res r_out;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= r_dly_div[DLY-1] ? w_div_res : r_dly_res[DLY-1];
        end
    end

    assign o_out.valid        = r_vld[fpq_pkg::PIPE_DEPTH-1];
    assign o_out.result_value = r_out.val;
    assign o_out.compare_true = r_out.cmp;
    assign o_out.error_code   = r_out.err;

`ifndef ASSERT_OFF
    a_cmp_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.compare_true) |->
            (o_out.result_value == '0 && o_out.error_code == fpq_pkg::ERR_OK))
        else $error("comparison result carries a value or an error");

    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.error_code != 2'd3))
        else $error("undefined error code on the output");

    a_div0_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.error_code == fpq_pkg::ERR_DIV0) |->
            (o_out.result_value == '0 && !o_out.compare_true))
        else $error("division by zero did not return zero");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid straight after reset");
`endif

endmodule

// File: bench/fixed_point_alu_q24_8_core_tb.sv
// Self-checking testbench for the Q24.8 fixed-point ALU core.
// Drives the input channel and checks every result against its own ALU model.
// Depends on fpq_pkg, fpq_in_if, fpq_out_if and fixed_point_alu_q24_8_core.
`timescale 1ns / 1ps

// Holds the results the ALU should produce, oldest first, and checks each
// result that leaves the core against the oldest one.
class alu_result_board;
    fpq_pkg::t_res pending[$];
    int            mismatches;
    int            unexpected;
    int            checked;

    function new();
        mismatches = 0;
        unexpected = 0;
        checked    = 0;
    endfunction

    function void note_operation(fpq_pkg::t_res res);
        pending.push_back(res);
    endfunction

    function void check_result(fpq_pkg::t_word val, logic cmp, logic [1:0] err);
        fpq_pkg::t_res want;
        if (pending.size() == 0) begin
            $error("result %0d arrived with nothing outstanding", val);
            unexpected++;
            return;
        end
        want = pending.pop_front();
        checked++;
        if (val !== want.val) begin
            $error("result_value: expected %0d, got %0d", want.val, val);
            mismatches++;
        end
        if (cmp !== want.cmp) begin
            $error("compare_true: expected %0b, got %0b", want.cmp, cmp);
            mismatches++;
        end
        if (err !== want.err) begin
            $error("error_code: expected %0d, got %0d", want.err, err);
            mismatches++;
        end
    endfunction
endclass

module fixed_point_alu_q24_8_core_tb;

    localparam longint WORD_MAX  = 64'sd2147483647;
    localparam longint WORD_MIN  = -64'sd2147483648;
    localparam int     RSTCYC    = 6;
    // Worst case is far below this: 1825 items, with their stalls and pipeline delay.
    localparam int     CYCLE_CAP = 1000000;

    logic i_clk;
    logic i_rst_n;

    fpq_in_if  in_ch ();
    fpq_out_if out_ch ();

    fixed_point_alu_q24_8_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    alu_result_board board;

    int  src_idle_pct;
    int  snk_idle_pct;
    int  hold_off;      // cycles the receiver still has to refuse results
    int  cycle_count;
    int  ops_sent;
    int  op_hits[16];

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Signed magnitude helpers at 64 bits; 32-bit operands never overflow here.
    function automatic fpq_pkg::t_res clamp_value(input longint v);
        fpq_pkg::t_res r;
        r.cmp = 1'b0;
        r.err = fpq_pkg::ERR_OK;
        if (v > WORD_MAX) begin
            v     = WORD_MAX;
            r.err = fpq_pkg::ERR_SAT;
        end else if (v < WORD_MIN) begin
            v     = WORD_MIN;
            r.err = fpq_pkg::ERR_SAT;
        end
        r.val = fpq_pkg::t_word'(v);
        return r;
    endfunction

    // Applies the sign to a rounded magnitude, then clamps it to the word range.
    function automatic fpq_pkg::t_res round_and_clamp(input logic neg,
                                                      input logic [127:0] mag);
        fpq_pkg::t_res r;
        logic [127:0]  lim;
        r.cmp = 1'b0;
        r.err = fpq_pkg::ERR_OK;
        lim   = neg ? 128'h8000_0000 : 128'h7fff_ffff;
        if (mag > lim) begin
            mag   = lim;
            r.err = fpq_pkg::ERR_SAT;
        end
        r.val = neg ? fpq_pkg::t_word'(32'd0 - mag[31:0]) : fpq_pkg::t_word'(mag[31:0]);
        return r;
    endfunction

    // The ALU behaviour for one operation.
    function automatic fpq_pkg::t_res alu_outcome(input logic [3:0] op,
                                                  input fpq_pkg::t_word a,
                                                  input fpq_pkg::t_word b);
        fpq_pkg::t_res r;
        longint        la;
        longint        lb;
        logic [127:0]  ma;
        logic [127:0]  mb;
        logic [127:0]  q;
        logic [127:0]  rem;
        logic          neg;
        la    = longint'(a);
        lb    = longint'(b);
        ma    = (la < 0) ? 128'(-la) : 128'(la);
        mb    = (lb < 0) ? 128'(-lb) : 128'(lb);
        neg   = (la < 0) != (lb < 0);
        r.val = '0;
        r.cmp = 1'b0;
        r.err = fpq_pkg::ERR_OK;
        case (op)
            fpq_pkg::OP_ADD: r = clamp_value(la + lb);
            fpq_pkg::OP_SUB: r = clamp_value(la - lb);
            fpq_pkg::OP_MUL: begin
                // Product has 16 fraction bits; round to 8, half away from zero.
                q = (ma * mb + 128'd128) >> fpq_pkg::FRAC_W;
                r = round_and_clamp(neg, q);
            end
            fpq_pkg::OP_DIV: begin
                if (mb == 0) begin
                    r.err = fpq_pkg::ERR_DIV0;
                end else begin
                    q   = (ma << fpq_pkg::FRAC_W) / mb;
                    rem = (ma << fpq_pkg::FRAC_W) % mb;
                    // An exact half rounds the magnitude up.
                    if (2 * rem >= mb)
                        q = q + 1;
                    r = round_and_clamp(neg, q);
                end
            end
            fpq_pkg::OP_GT: r.cmp = la > lb;
            fpq_pkg::OP_LT: r.cmp = la < lb;
            fpq_pkg::OP_GE: r.cmp = la >= lb;
            fpq_pkg::OP_LE: r.cmp = la <= lb;
            fpq_pkg::OP_EQ: r.cmp = la == lb;
            fpq_pkg::OP_NE: r.cmp = la != lb;
            fpq_pkg::OP_MIN: r.val = (la < lb) ? a : b;
            fpq_pkg::OP_MAX: r.val = (lb < la) ? a : b;
            fpq_pkg::OP_INC: r = clamp_value(la + 1);
            fpq_pkg::OP_DEC: r = clamp_value(la - 1);
            fpq_pkg::OP_FINT: r = clamp_value(la * 256);
            default: begin
                q = (ma + 128'd128) >> fpq_pkg::FRAC_W;
                r = round_and_clamp(la < 0, q);
            end
        endcase
        return r;
    endfunction

    // Offers one operation, with random idle cycles before it, and waits for
    // the transfer; the model result is noted once the core takes it. Valid
    // stays high on return so that operations can follow back to back.
    task automatic send_op(input logic [3:0] op, input fpq_pkg::t_word a,
                           input fpq_pkg::t_word b);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.kind      <= op;
        in_ch.operand_a <= a;
        in_ch.operand_b <= b;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        board.note_operation(alu_outcome(op, a, b));
        ops_sent++;
        op_hits[op]++;
        @(negedge i_clk);
    endtask

    // Stops offering and waits until every outstanding result has been checked.
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (board.pending.size() != 0)
            @(negedge i_clk);
    endtask

    // Operands lean on boundary values, small numbers and exact halves.
    function automatic fpq_pkg::t_word pick_operand();
        case ($urandom_range(9))
            0: return fpq_pkg::t_word'(32'h8000_0000);
            1: return fpq_pkg::t_word'(32'h7fff_ffff);
            2: return fpq_pkg::t_word'($urandom_range(3) - 1);
            3: return fpq_pkg::t_word'($signed($urandom_range(4095)) - 2048);
            4: return fpq_pkg::t_word'(($signed($urandom_range(511)) - 256)
                                       <<< fpq_pkg::FRAC_W);
            5: return fpq_pkg::t_word'(($signed($urandom_range(65535)) - 32768) * 128);
            default: return fpq_pkg::t_word'($urandom());
        endcase
    endfunction

    // Receiver: refuses results at random, or during a hold-off stretch.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_off > 0) begin
            out_ch.ready <= 1'b0;
            hold_off     <= hold_off - 1;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            board.check_result(out_ch.result_value, out_ch.compare_true,
                               out_ch.error_code);
    end

    // Cycle counter: a run that hangs ends here as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("fixed_point_alu_q24_8_core_tb failed");
            $finish;
        end
    end

    initial begin
        fpq_pkg::t_word a;
        fpq_pkg::t_word b;
        int    k;
        int    phase;
        board           = new();
        cycle_count     = 0;
        ops_sent        = 0;
        hold_off        = 0;
        src_idle_pct    = 0;
        snk_idle_pct    = 0;
        foreach (op_hits[i]) op_hits[i] = 0;
        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.kind      = fpq_pkg::OP_ADD;
        in_ch.operand_a = '0;
        in_ch.operand_b = '0;
        out_ch.ready    = 1'b0;
        repeat (RSTCYC) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: saturation at both bounds, division by zero and exact
        // halves, a tie for min, increment past the top and the
        // rounding of negative halves for fixed-to-integer.
        send_op(fpq_pkg::OP_ADD, 32'sh7fff_ffff, 32'sd1);
        send_op(fpq_pkg::OP_ADD, 32'sh8000_0000, -32'sd1);
        send_op(fpq_pkg::OP_SUB, 32'sh8000_0000, 32'sd1);
        send_op(fpq_pkg::OP_SUB, 32'sd0, 32'sh8000_0000);
        send_op(fpq_pkg::OP_MUL, 32'sh7fff_ffff, 32'sh7fff_ffff);
        send_op(fpq_pkg::OP_MUL, 32'sh8000_0000, 32'sd256);
        send_op(fpq_pkg::OP_MUL, -32'sd1, 32'sd128);
        send_op(fpq_pkg::OP_DIV, 32'sd1000, 32'sd0);
        send_op(fpq_pkg::OP_DIV, 32'sh8000_0000, -32'sd1);
        send_op(fpq_pkg::OP_DIV, 32'sd1, 32'sd512);
        send_op(fpq_pkg::OP_DIV, -32'sd3, 32'sd512);
        send_op(fpq_pkg::OP_GT, 32'sh8000_0000, 32'sh7fff_ffff);
        send_op(fpq_pkg::OP_LT, 32'sh8000_0000, 32'sh7fff_ffff);
        send_op(fpq_pkg::OP_GE, 32'sd5, 32'sd5);
        send_op(fpq_pkg::OP_LE, -32'sd5, -32'sd5);
        send_op(fpq_pkg::OP_EQ, 32'sd7, 32'sd7);
        send_op(fpq_pkg::OP_NE, 32'sd7, 32'sd7);
        send_op(fpq_pkg::OP_MIN, 32'sd9, 32'sd9);
        send_op(fpq_pkg::OP_MAX, -32'sd1, 32'sh8000_0000);
        send_op(fpq_pkg::OP_INC, 32'sh7fff_ffff, 32'sd0);
        send_op(fpq_pkg::OP_DEC, 32'sh8000_0000, 32'sd0);
        send_op(fpq_pkg::OP_FINT, 32'sh0080_0000, 32'sd0);
        send_op(fpq_pkg::OP_FINT, -32'sh0080_0000, 32'sd0);
        send_op(fpq_pkg::OP_TINT, -32'sd128, 32'sd0);
        send_op(fpq_pkg::OP_TINT, 32'sh7fff_ffff, 32'sd0);
        drain_results();

        // Random operations in three phases: two idling mixes, then full rate.
        for (phase = 0; phase < 3; phase++) begin
            src_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 46 : 0;
            snk_idle_pct = (phase == 0) ? 46 : (phase == 1) ? 14 : 0;
            for (k = 0; k < 600; k++) begin
                // Long receiver stall while the sender keeps going, so the
                // pipeline fills and the input ready drops.
                if (k == 300)
                    hold_off = 120;
                a = pick_operand();
                b = pick_operand();
                send_op(4'($urandom_range(15)), a, b);
            end
            // Sender pauses until every result of the phase has arrived.
            drain_results();
        end

        repeat (fpq_pkg::PIPE_DEPTH + 10) @(negedge i_clk);
        $display("covered %0d operations over all 16 opcodes, %0d results checked",
                 ops_sent, board.checked);
        $display("phases: directed edges, two idling mixes, full rate, long output stall");
        if (board.mismatches == 0 && board.unexpected == 0 && board.pending.size() == 0)
            $display("fixed_point_alu_q24_8_core_tb passed");
        else
            $display("fixed_point_alu_q24_8_core_tb failed");
        $finish;
    end
endmodule

// File: fixed_point_alu_q24_8_core.f
src/fpq_pkg.sv
src/fpq_in_if.sv
src/fpq_out_if.sv
src/fpq_div_pipe.sv
src/fixed_point_alu_q24_8_core.sv
bench/fixed_point_alu_q24_8_core_tb.sv
